[rtl/core/grid_bfs_path_finder_unit_macros.svh]
// Assertion macros for the grid path finder.
// Used by the RTL files that carry assertions.
`ifndef GRID_BFS_PATH_FINDER_UNIT_MACROS_SVH
`define GRID_BFS_PATH_FINDER_UNIT_MACROS_SVH
`define GBP_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define GBP_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

[rtl/core/gbp_pkg.sv]
// Shared constants and types of the grid path finder.
// No dependencies.
package gbp_pkg;
   localparam int MAX_WIDTH = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int CW = XW + YW;
   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_FIND = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;
   localparam logic [2:0] ST_FOUND = 3'd0;
   localparam logic [2:0] ST_THERE = 3'd1;
   localparam logic [2:0] ST_OUT = 3'd2;
   localparam logic [2:0] ST_BLOCKED = 3'd3;
   localparam logic [2:0] ST_UNREACH = 3'd4;
   localparam logic [2:0] ST_BADSTEP = 3'd5;
   localparam logic [1:0] DIR_UP = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_LEFT = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;
   localparam logic [0:0] CSR_WIDTH = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;
endpackage

[rtl/core/gbp_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module gbp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/core/grid_bfs_path_finder_unit.sv]
// Grid path finder: a load writes the blocked store from S_IDLE; a read passes S_RD, S_TWAIT.
// A find runs the target checks, clears the visited store in S_VCLR, dequeues each cell in
// S_POP and S_POPW, probes a neighbour in S_NB (open ones also in S_NBW and S_NBD) and walks
// each path step through S_BT, S_BTW, S_FILL and S_FILLW. Results come in the cycle after
// the sequencer ends; the receiver cannot stall. Synchronous reset sets the grid to 64 by 64,
// stored length to zero, and clears the blocked store in S_CLR, during which busy is high.
module grid_bfs_path_finder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic        req_blocked,
   input  logic [5:0]  req_start_x,
   input  logic [5:0]  req_start_y,
   input  logic [11:0] req_step_index,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_path_length,
   output logic [1:0]  rsp_direction,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import gbp_pkg::*;
   `include "grid_bfs_path_finder_unit_macros.svh"

   typedef enum logic [15:0] {
      S_CLR = 16'h0001, S_IDLE = 16'h0002, S_RD = 16'h0004, S_TCHK = 16'h0008,
      S_TWAIT = 16'h0010, S_POP = 16'h0020, S_POPW = 16'h0040, S_NB = 16'h0080,
      S_NBW = 16'h0100, S_NBD = 16'h0200, S_BT = 16'h0400, S_BTW = 16'h0800,
      S_FILL = 16'h1000, S_FILLW = 16'h2000, S_DONE = 16'h4000, S_VCLR = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] gw_ff, gh_ff;
   logic [CW:0] cnt_ff, cnt_in;
   logic [CW:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] cur_ff, cur_in, tgt_ff, tgt_in, src_ff, src_in, nb_ff, nb_in;
   logic [1:0] k_ff, k_in;
   logic [11:0] len_ff, len_in, slen_ff, slen_in;
   logic [11:0] sidx_ff, sidx_in;
   logic bt_pass_ff, bt_pass_in;
   logic [2:0] st_ff, st_in;
   logic [1:0] kind_ff, kind_in;
   logic v_ff, v_in;
   logic [2:0] ost_ff, ost_in;
   logic [11:0] olen_ff, olen_in;
   logic [1:0] odir_ff, odir_in;

   logic b_we, b_wd, b_rd; logic [CW-1:0] b_wa, b_ra;
   logic vi_we, vi_wd, vi_rd; logic [CW-1:0] vi_wa, vi_ra;
   logic p_we; logic [1:0] p_wd, p_rd; logic [CW-1:0] p_wa, p_ra;
   logic q_we; logic [CW-1:0] q_wd, q_rd, q_wa, q_ra;
   logic s_we; logic [1:0] s_wd, s_rd; logic [CW-1:0] s_wa, s_ra;

   gbp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk (.clock, .wr_en(b_we), .wr_addr(b_wa),
      .wr_data(b_wd), .rd_addr(b_ra), .rd_data(b_rd));
   gbp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (.clock, .wr_en(vi_we), .wr_addr(vi_wa),
      .wr_data(vi_wd), .rd_addr(vi_ra), .rd_data(vi_rd));
   gbp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_par (.clock, .wr_en(p_we), .wr_addr(p_wa),
      .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd));
   gbp_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_que (.clock, .wr_en(q_we), .wr_addr(q_wa),
      .wr_data(q_wd), .rd_addr(q_ra), .rd_data(q_rd));
   gbp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_path (.clock, .wr_en(s_we), .wr_addr(s_wa),
      .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd));

   logic [XW-1:0] cx; logic [YW-1:0] cy;
   logic [XW:0] nx; logic [YW:0] ny;
   logic nb_ok;
   logic [6:0] cfg_v;

   assign cx = cur_ff[XW-1:0];
   assign cy = cur_ff[CW-1:XW];

   // Neighbour unit for S_NB: offset of direction k from the current cell and its in-grid check.
   always_comb begin
      nx = {1'b0, cx};
      ny = {1'b0, cy};
      nb_ok = 1'b1;
      case (k_ff)
         DIR_UP: begin
            ny = {1'b0, cy} - 1'b1;
            nb_ok = (cy != '0);
         end
         DIR_DOWN: ny = {1'b0, cy} + 1'b1;
         DIR_LEFT: begin
            nx = {1'b0, cx} - 1'b1;
            nb_ok = (cx != '0);
         end
         default: nx = {1'b0, cx} + 1'b1;
      endcase
      if ({1'b0, nx} >= {1'b0, gw_ff} || {1'b0, ny} >= {1'b0, gh_ff}) begin
         nb_ok = 1'b0;
      end
   end

   assign cfg_v = (csr_data == 7'd0) ? 7'd1 : csr_data;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; head_in = head_ff; tail_in = tail_ff;
      cur_in = cur_ff; tgt_in = tgt_ff; src_in = src_ff; nb_in = nb_ff; k_in = k_ff;
      len_in = len_ff; slen_in = slen_ff; sidx_in = sidx_ff;
      bt_pass_in = bt_pass_ff; st_in = st_ff; kind_in = kind_ff;
      v_in = 1'b0; ost_in = ost_ff; olen_in = olen_ff; odir_in = odir_ff;
      b_we = 1'b0; b_wa = {req_cell_y, req_cell_x};
      b_wd = req_blocked; b_ra = tgt_ff;
      vi_we = 1'b0; vi_wa = cnt_ff[CW-1:0]; vi_wd = 1'b0; vi_ra = nb_ff;
      p_we = 1'b0; p_wa = nb_ff; p_wd = k_ff; p_ra = cur_ff;
      q_we = 1'b0; q_wa = tail_ff[CW-1:0]; q_wd = nb_ff; q_ra = head_ff[CW-1:0];
      s_we = 1'b0; s_wa = len_ff[CW-1:0]; s_wd = p_rd; s_ra = sidx_ff[CW-1:0];
      case (state_ff)
         S_CLR: begin
            b_we = 1'b1; b_wa = cnt_ff[CW-1:0]; b_wd = 1'b0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (CW+1)'(CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind; sidx_in = req_step_index;
               tgt_in = {req_cell_y, req_cell_x}; src_in = {req_start_y, req_start_x};
               case (req_kind)
                  KIND_LOAD: b_we = 1'b1;
                  KIND_FIND: begin
                     slen_in = '0;
                     if (req_start_x == req_cell_x && req_start_y == req_cell_y) begin
                        st_in = ST_THERE; state_in = S_DONE;
                     end else if ({1'b0, req_cell_x} >= gw_ff ||
                                  {1'b0, req_cell_y} >= gh_ff) begin
                        st_in = ST_OUT; state_in = S_DONE;
                     end else state_in = S_TCHK;
                  end
                  KIND_READ: state_in = S_RD;
                  default: ;
               endcase
            end
         end
         S_RD: state_in = S_TWAIT;
         S_TCHK: state_in = S_TWAIT;
         S_TWAIT: begin
            if (kind_ff == KIND_READ) begin
               v_in = 1'b1; state_in = S_IDLE; odir_in = 2'd0;
               if (sidx_ff >= slen_ff) begin
                  ost_in = ST_BADSTEP; olen_in = '0;
               end else begin
                  ost_in = ST_FOUND; olen_in = slen_ff; odir_in = s_rd;
               end
            end else if (b_rd) begin
               st_in = ST_BLOCKED; state_in = S_DONE;
            end else if ({1'b0, src_ff[XW-1:0]} >= gw_ff ||
                         {1'b0, src_ff[CW-1:XW]} >= gh_ff) begin
               st_in = ST_UNREACH; state_in = S_DONE;
            end else begin
               cnt_in = '0; state_in = S_VCLR;
            end
         end
         S_VCLR: begin
            vi_we = 1'b1; cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (CW+1)'(CELLS)) begin
               vi_wa = src_ff; vi_wd = 1'b1;
               q_we = 1'b1; q_wa = '0; q_wd = src_ff;
               head_in = '0; tail_in = (CW+1)'(1); state_in = S_POP;
            end
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               st_in = ST_UNREACH; state_in = S_DONE;
            end else state_in = S_POPW;
         end
         S_POPW: begin
            cur_in = q_rd; head_in = head_ff + 1'b1; k_in = DIR_UP;
            if (q_rd == tgt_ff) begin
               cur_in = tgt_ff; len_in = '0; bt_pass_in = 1'b0; state_in = S_BT;
            end else state_in = S_NB;
         end
         S_NB: begin
            nb_in = {ny[YW-1:0], nx[XW-1:0]};
            if (nb_ok) state_in = S_NBW;
            else if (k_ff == DIR_RIGHT) state_in = S_POP;
            else k_in = k_ff + 1'b1;
         end
         S_NBW: begin
            b_ra = nb_ff; state_in = S_NBD;
         end
         S_NBD: begin
            if (!vi_rd && !b_rd) begin
               vi_we = 1'b1; vi_wa = nb_ff; vi_wd = 1'b1; p_we = 1'b1;
               if (tail_ff < CELLS) begin
                  q_we = 1'b1; tail_in = tail_ff + 1'b1;
               end
            end
            if (k_ff == DIR_RIGHT) state_in = S_POP;
            else begin
               k_in = k_ff + 1'b1; state_in = S_NB;
            end
         end
         S_BT: begin
            if (bt_pass_ff ? (len_ff == '0) : (cur_ff == src_ff)) begin
               if (bt_pass_ff) begin
                  st_in = ST_FOUND; slen_in = slen_ff; state_in = S_DONE;
               end else begin
                  slen_in = len_ff; bt_pass_in = 1'b1; cur_in = tgt_ff;
               end
            end else state_in = S_BTW;
         end
         S_BTW: state_in = S_FILL;
         S_FILL: begin
            if (bt_pass_ff) begin
               len_in = len_ff - 1'b1; s_we = 1'b1; s_wa = len_in[CW-1:0];
            end else len_in = len_ff + 1'b1;
            case (p_rd)
               DIR_UP: cur_in = {cy + 1'b1, cx};
               DIR_DOWN: cur_in = {cy - 1'b1, cx};
               DIR_LEFT: cur_in = {cy, cx + 1'b1};
               default: cur_in = {cy, cx - 1'b1};
            endcase
            state_in = S_FILLW;
         end
         S_FILLW: state_in = S_BT;
         S_DONE: begin
            v_in = 1'b1; ost_in = st_ff; odir_in = 2'd0;
            olen_in = (st_ff == ST_FOUND) ? slen_ff : 12'd0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; cnt_ff <= '0; gw_ff <= 7'd64; gh_ff <= 7'd64;
         slen_ff <= '0; v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; slen_ff <= slen_in; v_ff <= v_in;
         if (csr_write) begin
            if (csr_index == CSR_WIDTH) gw_ff <= (cfg_v > MAX_WIDTH) ? 7'(MAX_WIDTH) : cfg_v;
            else gh_ff <= (cfg_v > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg_v;
         end
      end
      head_ff <= head_in; tail_ff <= tail_in; cur_ff <= cur_in; tgt_ff <= tgt_in;
      src_ff <= src_in; nb_ff <= nb_in; k_ff <= k_in; len_ff <= len_in;
      sidx_ff <= sidx_in; bt_pass_ff <= bt_pass_in; st_ff <= st_in; kind_ff <= kind_in;
      ost_ff <= ost_in; olen_ff <= olen_in; odir_ff <= odir_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = v_ff;
   assign rsp_status = ost_ff;
   assign rsp_path_length = olen_ff;
   assign rsp_direction = odir_ff;

   `GBP_ASSERT_NXT(a_idle_after_rsp, clock, reset, v_in, !busy)
   `GBP_ASSERT_IMP(a_head_le_tail, clock, reset, state_ff == S_POP, head_ff <= tail_ff)
   `GBP_ASSERT_IMP(a_bad_dir_zero, clock, reset, rsp_valid && rsp_status != ST_FOUND,
      rsp_path_length == 12'd0 && rsp_direction == 2'd0)
endmodule
